// ===== hdl/clcd_pkg.sv =====
// Shared types, constants and lookup functions for the character LCD nibble engine.
`timescale 1ns / 1ps
package clcd_pkg;

  localparam int unsigned ClcdQueueDepth = 2;
  localparam logic [5:0] CharsPerLineReset = 6'd20;
  localparam logic [5:0] LineCountMax = 6'd63;
  localparam logic [3:0] InitLastStep = 4'd11;
  localparam logic [3:0] InitWakeSteps = 4'd3;

  localparam logic [7:0] RowBase1 = 8'h80;
  localparam logic [7:0] RowBase2 = 8'hC0;
  localparam logic [7:0] RowBase3 = 8'h94;
  localparam logic [7:0] RowBase4 = 8'hD4;
  localparam logic [7:0] CyrFirst = 8'hC0;

  typedef enum logic [2:0] {
    CMD_INSTR      = 3'd0,
    CMD_RAW_CHAR   = 3'd1,
    CMD_CYR_CHAR   = 3'd2,
    CMD_CURSOR     = 3'd3,
    CMD_INIT       = 3'd4,
    CMD_LONG_START = 3'd5,
    CMD_LONG_CHAR  = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] value;
    logic [2:0] row;
    logic [7:0] column;
  } clcd_in_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       register_select;
    logic       wait_busy;
    logic       last;
  } clcd_out_t;

  // One classified item: either the init sequence or one or two bytes.
  typedef struct packed {
    logic       init;
    logic       two;
    logic [7:0] b0;
    logic       rs0;
    logic [7:0] b1;
    logic       rs1;
  } clcd_job_t;

  typedef struct packed {
    logic mid_job;
    logic head_valid;
  } clcd_back_status_t;

  localparam logic [7:0] CyrRom [64] = '{
    8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
    8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
    8'hac, 8'he2, 8'had, 8'hae, 8'h62, 8'haf, 8'hb0, 8'hb1,
    8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
    8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe,
    8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
    8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7
  };

  function automatic logic [7:0] cyr_map(input logic [7:0] c);
    if (c >= CyrFirst) begin
      return CyrRom[c[5:0]];
    end
    return c;
  endfunction

  // Nibbles of the power-on sequence, in order.
  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    logic [3:0] n;
    case (step)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5:             n = 4'hF;
      4'd6:             n = 4'h0;
      4'd7:             n = 4'h1;
      4'd8:             n = 4'h0;
      4'd9:             n = 4'h6;
      4'd10:            n = 4'h0;
      4'd11:            n = 4'hE;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/char_lcd_nibble_command_engine_core.sv =====
// An accepted item is written into the job queue; its nibbles are then registered into out_o.
// Throughput: one nibble per cycle from the sequencer unless the output stalls; a byte command
// is 2 nibbles, a wrapping long-string char 4, init 12; dropped commands are consumed, not queued.
// The job queue holds QueueDepth classified items so input and output stall independently.
// Reset (async, active low): queue empty, output invalid, line count 0, line length 20.
`timescale 1ns / 1ps
module char_lcd_nibble_command_engine_core #(
  parameter int unsigned QueueDepth = clcd_pkg::ClcdQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clcd_pkg::clcd_in_t  in_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output clcd_pkg::clcd_out_t out_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i
);
  import clcd_pkg::*;

  clcd_job_t          push_job, head_job;
  logic               push, pop, q_empty, q_full;
  logic [$clog2(QueueDepth+1)-1:0] q_count;
  clcd_back_status_t  back_status;

  clcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  clcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  clcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (!q_empty),
    .pop_o       (pop),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (back_status)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("queue count beyond depth");

  a_mid_job_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.mid_job |-> back_status.head_valid)
    else $error("sequencer mid-job with empty queue");

  a_wake_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.wait_busy) |->
      (out_o.nibble == 4'h3 && !out_o.register_select && !out_o.last))
    else $error("bad init wake-up nibble");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_valid_o && out_o.last))
    else $error("job retired without last nibble");

endmodule

// ===== hdl/clcd_front.sv =====
// Front end: accepts items, classifies them into jobs and tracks the long-string count.
`timescale 1ns / 1ps
module clcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clcd_pkg::clcd_in_t  in_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i,
  input  logic                q_full_i,
  output logic                push_o,
  output clcd_pkg::clcd_job_t job_o
);
  import clcd_pkg::*;

  logic [5:0] chars_per_line_q;
  logic [5:0] count_q, count_d;
  logic       accept;
  logic       job_ok;
  logic [7:0] row_base;
  logic       row_ok;

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    row_ok = 1'b1;
    case (in_i.row)
      3'd1:    row_base = RowBase1;
      3'd2:    row_base = RowBase2;
      3'd3:    row_base = RowBase3;
      3'd4:    row_base = RowBase4;
      default: begin
        row_base = RowBase1;
        row_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    job_o = '0;
    job_ok = 1'b1;
    count_d = count_q;
    case (cmd_e'(in_i.command))
      CMD_INSTR: begin
        job_o.b0 = in_i.value;
      end
      CMD_RAW_CHAR: begin
        job_o.b0 = in_i.value;
        job_o.rs0 = 1'b1;
      end
      CMD_CYR_CHAR: begin
        job_o.b0 = cyr_map(in_i.value);
        job_o.rs0 = 1'b1;
      end
      CMD_CURSOR: begin
        // base + column - 1, wrapping at 256
        job_o.b0 = row_base + in_i.column + 8'hFF;
        job_ok = row_ok;
      end
      CMD_INIT: begin
        job_o.init = 1'b1;
      end
      CMD_LONG_START: begin
        job_o.b0 = RowBase1;
        count_d = '0;
      end
      CMD_LONG_CHAR: begin
        if (count_q == chars_per_line_q) begin
          job_o.two = 1'b1;
          job_o.b0 = RowBase2;
          job_o.b1 = cyr_map(in_i.value);
          job_o.rs1 = 1'b1;
        end else begin
          job_o.b0 = cyr_map(in_i.value);
          job_o.rs0 = 1'b1;
        end
        if (count_q != LineCountMax) begin
          count_d = count_q + 6'd1;
        end
      end
      default: begin
        job_ok = 1'b0;
      end
    endcase
  end

  assign push_o = accept && job_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_per_line_q <= CharsPerLineReset;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        chars_per_line_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

endmodule

// ===== hdl/clcd_queue.sv =====
// Small job FIFO between the front end and the nibble sequencer.
`timescale 1ns / 1ps
module clcd_queue #(
  parameter int unsigned Depth = clcd_pkg::ClcdQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  clcd_pkg::clcd_job_t data_i,
  input  logic                pop_i,
  output clcd_pkg::clcd_job_t data_o,
  output logic                empty_o,
  output logic                full_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import clcd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clcd_job_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/clcd_back.sv =====
// Back end: feeds the head job one nibble per cycle, unless stalled, into the output register.
`timescale 1ns / 1ps
module clcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clcd_pkg::clcd_job_t job_i,
  input  logic                job_valid_i,
  output logic                pop_o,
  output clcd_pkg::clcd_out_t out_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clcd_pkg::clcd_back_status_t status_o
);
  import clcd_pkg::*;

  logic [3:0] step_q;
  logic       out_valid_q;
  clcd_out_t  out_q, nib;
  logic       advance;
  logic [7:0] cur_byte;

  always_comb begin
    nib = '0;
    cur_byte = step_q[1] ? job_i.b1 : job_i.b0;
    if (job_i.init) begin
      nib.nibble = init_nibble(step_q);
      nib.register_select = 1'b0;
      nib.wait_busy = (step_q >= InitWakeSteps);
      nib.last = (step_q == InitLastStep);
    end else begin
      nib.nibble = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
      nib.register_select = step_q[1] ? job_i.rs1 : job_i.rs0;
      nib.wait_busy = 1'b1;
      nib.last = job_i.two ? (step_q == 4'd3) : (step_q == 4'd1);
    end
  end

  assign advance = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = advance && nib.last;
  assign out_o = out_q;
  assign out_valid_o = out_valid_q;
  assign status_o.mid_job = (step_q != '0);
  assign status_o.head_valid = job_valid_i;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= nib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        step_q <= nib.last ? 4'd0 : step_q + 4'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
